// ----- hdl/multi_pattern_motif_scanner_assert.svh -----
// ----------------------------------------------------------------------------
// multi_pattern_motif_scanner_assert
// Assertion macros used by the scanner RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_MOTIF_SCANNER_ASSERT_SVH
`define MULTI_PATTERN_MOTIF_SCANNER_ASSERT_SVH

// same-cycle implication
`define MPMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mpms_pkg.sv -----
// ----------------------------------------------------------------------------
// mpms_pkg
// Types and constants for the multi-pattern motif scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpms_pkg;

    localparam int MAX_PATTERNS    = 4;
    localparam int MAX_PATTERN_LEN = 8;
    localparam int POSITION_BITS   = 31;
    localparam int SITE_BITS       = POSITION_BITS + 2;
    localparam int SYM_BITS        = 8;
    localparam int INDEX_BITS      = 32;
    localparam int CNT_BITS        = 3;
    localparam int LEN_BITS        = 4;
    localparam int OFF_BITS        = 6;
    localparam int PAT_BITS        = 64;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CELL_IDX_BITS   = $clog2(MAX_PATTERN_LEN);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PATTERN_COUNT  = 3'd0,
        REG_PATTERN_LENGTH = 3'd1,
        REG_SITE_OFFSET    = 3'd2,
        REG_PATTERN_ZERO   = 3'd3,
        REG_PATTERN_ONE    = 3'd4,
        REG_PATTERN_TWO    = 3'd5,
        REG_PATTERN_THREE  = 3'd6
    } cfg_reg_e;

    typedef logic [SYM_BITS-1:0] sym_t;
    typedef logic [MAX_PATTERNS-1:0][SYM_BITS-1:0] pat_bytes_t;
    typedef logic [MAX_PATTERNS-1:0] hit_t;

    // effective settings seen by the datapath
    typedef struct packed {
        logic [CNT_BITS-1:0]                      count;
        logic [LEN_BITS-1:0]                      length;
        logic signed [OFF_BITS-1:0]               offset;
        logic [MAX_PATTERNS-1:0][PAT_BITS-1:0]    pattern;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/mpms_cfg.sv -----
// ----------------------------------------------------------------------------
// mpms_cfg
// Configuration registers with count and length clamping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpms_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [mpms_pkg::CFG_IDX_BITS-1:0] wr_index,
    input  wire logic [mpms_pkg::PAT_BITS-1:0] wr_data,
    output mpms_pkg::cfg_t                     cfg
);
    import mpms_pkg::*;

    logic [CNT_BITS-1:0]                   count_reg;
    logic [LEN_BITS-1:0]                   length_reg;
    logic [OFF_BITS-1:0]                   offset_reg;
    logic [MAX_PATTERNS-1:0][PAT_BITS-1:0] pattern_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= CNT_BITS'(1);
            length_reg  <= LEN_BITS'(2);
            offset_reg  <= OFF_BITS'(2);
            pattern_reg[0] <= PAT_BITS'(64'h6761);
            for (int p = 1; p < MAX_PATTERNS; p++)
                pattern_reg[p] <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_reg_e'(wr_index))
                REG_PATTERN_COUNT:  count_reg      <= wr_data[CNT_BITS-1:0];
                REG_PATTERN_LENGTH: length_reg     <= wr_data[LEN_BITS-1:0];
                REG_SITE_OFFSET:    offset_reg     <= wr_data[OFF_BITS-1:0];
                REG_PATTERN_ZERO:   pattern_reg[0] <= wr_data;
                REG_PATTERN_ONE:    pattern_reg[1] <= wr_data;
                REG_PATTERN_TWO:    pattern_reg[2] <= wr_data;
                REG_PATTERN_THREE:  pattern_reg[3] <= wr_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        cfg.count = (count_reg > CNT_BITS'(MAX_PATTERNS)) ? CNT_BITS'(MAX_PATTERNS)
                                                          : count_reg;
        if (length_reg == '0)
            cfg.length = LEN_BITS'(1);
        else if (length_reg > LEN_BITS'(MAX_PATTERN_LEN))
            cfg.length = LEN_BITS'(MAX_PATTERN_LEN);
        else
            cfg.length = length_reg;
        cfg.offset  = offset_reg;
        cfg.pattern = pattern_reg;
    end

endmodule

`default_nettype wire

// ----- hdl/mpms_cell.sv -----
// ----------------------------------------------------------------------------
// mpms_cell
// One window slot: holds a character, passes it on, compares it to the
// pattern bytes aligned with this slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpms_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 shift_en,
    input  wire mpms_pkg::sym_t       char_in,
    input  wire logic                 active,
    input  wire mpms_pkg::pat_bytes_t pat_bytes,
    output mpms_pkg::sym_t            char_out,
    output mpms_pkg::hit_t            hit
);
    import mpms_pkg::*;

    sym_t char_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            char_reg <= '0;
        else if (shift_en)
            char_reg <= char_in;
    end

    // slots past the pattern length always agree
    always_comb
    begin
        for (int p = 0; p < MAX_PATTERNS; p++)
            hit[p] = !active || (char_reg == pat_bytes[p]);
    end

    assign char_out = char_reg;

endmodule

`default_nettype wire

// ----- hdl/multi_pattern_motif_scanner.sv -----
// ----------------------------------------------------------------------------
// multi_pattern_motif_scanner
// Streams sequence characters through a chain of window cells and reports
// the site position of each window that equals an enabled pattern.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  item     | item_valid / item_stall | symbol, segment_begin, segment_base
//  site     | site_valid / site_stall | site_position
//  cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  One word per cycle sustained while item_stall is low. A word shifts
//  the cell chain at accept and sets a pending compare, which runs once
//  the output register is free; a match registers the position and
//  site_valid. Reset clears the window, segment index and base, and
//  loads the register defaults. item_stall rises only when a compare is
//  pending and the output register is full and stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multi_pattern_motif_scanner_assert.svh"

module multi_pattern_motif_scanner (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic [mpms_pkg::SYM_BITS-1:0]       symbol,
    input  wire logic                                segment_begin,
    input  wire logic [mpms_pkg::POSITION_BITS-1:0]  segment_base,
    output logic                                     site_valid,
    input  wire logic                                site_stall,
    output logic signed [mpms_pkg::SITE_BITS-1:0]    site_position,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mpms_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [mpms_pkg::PAT_BITS-1:0]       cfg_data
);
    import mpms_pkg::*;

    cfg_t cfg;

    logic                       accept;
    logic                       eval_fire;
    logic                       eval_reg,  eval_next;
    logic                       valid_reg, valid_next;
    logic [SITE_BITS-1:0]       pos_reg,   pos_next;
    logic [INDEX_BITS-1:0]      idx_reg,   idx_next;
    logic [POSITION_BITS-1:0]   base_reg,  base_next;

    sym_t                       chain_in  [MAX_PATTERN_LEN];
    sym_t                       chain_out [MAX_PATTERN_LEN];
    logic [MAX_PATTERN_LEN-1:0] active;
    pat_bytes_t                 pat_bytes [MAX_PATTERN_LEN];
    hit_t                       hit       [MAX_PATTERN_LEN];
    hit_t                       hit_all;
    logic                       match;
    logic [INDEX_BITS-1:0]      start;

    assign cfg_ready = 1'b1;

    mpms_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign item_stall = eval_reg && valid_reg && site_stall;
    assign accept     = item_valid && !item_stall;
    assign eval_fire  = eval_reg && !(valid_reg && site_stall);

    // chain feed and per-slot pattern alignment
    always_comb
    begin
        logic [LEN_BITS-1:0] jw;
        chain_in[0] = symbol;
        for (int i = 1; i < MAX_PATTERN_LEN; i++)
            chain_in[i] = segment_begin ? '0 : chain_out[i-1];
        for (int i = 0; i < MAX_PATTERN_LEN; i++)
        begin
            active[i] = LEN_BITS'(i) < cfg.length;
            jw = cfg.length - LEN_BITS'(i) - LEN_BITS'(1);
            for (int p = 0; p < MAX_PATTERNS; p++)
                pat_bytes[i][p] =
                    cfg.pattern[p][SYM_BITS*jw[CELL_IDX_BITS-1:0] +: SYM_BITS];
        end
    end

    for (genvar g = 0; g < MAX_PATTERN_LEN; g++)
    begin : g_cell
        mpms_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (accept),
            .char_in   (chain_in[g]),
            .active    (active[g]),
            .pat_bytes (pat_bytes[g]),
            .char_out  (chain_out[g]),
            .hit       (hit[g])
        );
    end

    always_comb
    begin
        hit_all = '1;
        for (int i = 0; i < MAX_PATTERN_LEN; i++)
            hit_all = hit_all & hit[i];
        match = 1'b0;
        for (int p = 0; p < MAX_PATTERNS; p++)
            if (CNT_BITS'(p) < cfg.count)
                match = match | hit_all[p];
        match = match && (idx_reg >= INDEX_BITS'(cfg.length));
        start = idx_reg - INDEX_BITS'(cfg.length);
        pos_next = SITE_BITS'(base_reg) + SITE_BITS'(start)
                 + SITE_BITS'(cfg.offset);
    end

    always_comb
    begin
        idx_next  = idx_reg;
        base_next = base_reg;
        if (accept)
        begin
            if (segment_begin)
            begin
                idx_next  = INDEX_BITS'(1);
                base_next = segment_base;
            end
            else if (idx_reg != '1)
                idx_next = idx_reg + INDEX_BITS'(1);
        end

        eval_next = eval_reg;
        if (accept)
            eval_next = 1'b1;
        else if (eval_fire)
            eval_next = 1'b0;

        valid_next = valid_reg;
        if (eval_fire)
            valid_next = match;
        else if (!site_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            base_reg  <= '0;
            eval_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            base_reg  <= base_next;
            eval_reg  <= eval_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_fire && match)
            pos_reg <= pos_next;
    end

    assign site_valid    = valid_reg;
    assign site_position = pos_reg;

    `MPMS_ASSERT_NEXT(a_accept_evals, clk, rst_n, accept, eval_reg,
        "accepted word left no pending compare")
    `MPMS_ASSERT_NEXT(a_match_shows, clk, rst_n, eval_fire && match, site_valid,
        "matching window produced no site")
    `MPMS_ASSERT_NEXT(a_begin_index, clk, rst_n, accept && segment_begin,
        idx_reg == INDEX_BITS'(1), "segment begin did not restart index")
    `MPMS_ASSERT_NOW(a_site_source, clk, rst_n, $rose(site_valid), $past(eval_reg),
        "site raised without a pending compare")

endmodule

`default_nettype wire

// ----- sim/multi_pattern_motif_scanner_tb.sv -----
// ----------------------------------------------------------------------------
// multi_pattern_motif_scanner_tb
// Streams sequence characters into the motif scanner under several register
// settings and idle/stall mixes. A local model of the window, segment index
// and base predicts every reported site; each site word from the block is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_pattern_motif_scanner_tb;

    import mpms_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          item_valid    = 1'b0;
    logic                          item_stall;
    logic [SYM_BITS-1:0]           symbol        = '0;
    logic                          segment_begin = 1'b0;
    logic [POSITION_BITS-1:0]      segment_base  = '0;
    logic                          site_valid;
    logic                          site_stall    = 1'b0;
    logic signed [SITE_BITS-1:0]   site_position;
    logic                          cfg_valid     = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_BITS-1:0]       cfg_index     = '0;
    logic [PAT_BITS-1:0]           cfg_data      = '0;

    // scanner model state
    cfg_t                          shadow_cfg;
    sym_t                          scan_window [MAX_PATTERN_LEN];
    logic [INDEX_BITS-1:0]         scan_index;
    logic [POSITION_BITS-1:0]      scan_base;

    logic signed [SITE_BITS-1:0]   pending_sites [$];
    int                            fail_count     = 0;
    int                            cycle_count    = 0;
    int                            send_idle_pct  = 0;
    int                            recv_stall_pct = 0;

    multi_pattern_motif_scanner DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .symbol        (symbol),
        .segment_begin (segment_begin),
        .segment_base  (segment_base),
        .site_valid    (site_valid),
        .site_stall    (site_stall),
        .site_position (site_position),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned active_length();
        if (shadow_cfg.length == '0)
            return 1;
        if (shadow_cfg.length > LEN_BITS'(MAX_PATTERN_LEN))
            return MAX_PATTERN_LEN;
        return 32'(shadow_cfg.length);
    endfunction

    function automatic int unsigned active_count();
        if (shadow_cfg.count > CNT_BITS'(MAX_PATTERNS))
            return MAX_PATTERNS;
        return 32'(shadow_cfg.count);
    endfunction

    // shift one character in; returns 1 with the site when the window matches
    function automatic bit scan_symbol(input sym_t sym, input bit seg_begin,
                                       input logic [POSITION_BITS-1:0] base,
                                       output logic signed [SITE_BITS-1:0] site);
        int unsigned           len;
        int unsigned           cnt;
        int                    i;
        int                    p;
        int                    j;
        bit                    hit;
        bit                    same;
        logic [INDEX_BITS-1:0] start;
        len  = active_length();
        cnt  = active_count();
        hit  = 1'b0;
        site = '0;
        if (seg_begin)
        begin
            for (i = 0; i < MAX_PATTERN_LEN; i++)
                scan_window[i] = '0;
            scan_index = '0;
            scan_base  = base;
        end
        for (i = MAX_PATTERN_LEN - 1; i > 0; i--)
            scan_window[i] = scan_window[i-1];
        scan_window[0] = sym;
        if (scan_index != '1)
            scan_index++;
        if (scan_index < len)
            return 1'b0;
        for (p = 0; p < cnt; p++)
        begin
            same = 1'b1;
            for (j = 0; j < len; j++)
                if (scan_window[len-1-j] != shadow_cfg.pattern[p][8*j +: 8])
                    same = 1'b0;
            hit |= same;
        end
        if (!hit)
            return 1'b0;
        start = scan_index - len;
        site  = SITE_BITS'(scan_base) + SITE_BITS'(start)
              + {{(SITE_BITS-OFF_BITS){shadow_cfg.offset[OFF_BITS-1]}}, shadow_cfg.offset};
        return 1'b1;
    endfunction

    function automatic sym_t random_nucleotide();
        case ($urandom_range(0, 3))
            0:       return "a";
            1:       return "c";
            2:       return "g";
            default: return "t";
        endcase
    endfunction

    function automatic logic [POSITION_BITS-1:0] random_base();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return POSITION_BITS'($urandom);
        endcase
    endfunction

    // result side: random stall, check each accepted site word
    always @(posedge clk)
    begin
        logic signed [SITE_BITS-1:0] want;
        site_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
        if (rst_n && site_valid && !site_stall)
        begin
            if (pending_sites.size() == 0)
            begin
                $error("site_position: unexpected word, expected none, actual %0d",
                       site_position);
                fail_count++;
            end
            else
            begin
                want = pending_sites.pop_front();
                if (site_position !== want)
                begin
                    $error("site_position mismatch: expected %0d, actual %0d",
                           want, site_position);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_word(input sym_t sym, input bit seg_begin,
                             input logic [POSITION_BITS-1:0] base);
        int                          gap;
        logic signed [SITE_BITS-1:0] site;
        gap = 0;
        while ((send_idle_pct > 0) && ($urandom_range(0, 99) < send_idle_pct))
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid    <= 1'b1;
        symbol        <= sym;
        segment_begin <= seg_begin;
        segment_base  <= base;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (scan_symbol(sym, seg_begin, base, site))
            pending_sites = {pending_sites, site};
    endtask

    // stop sending, let all sites come back and the compare stage empty
    task automatic drain();
        item_valid <= 1'b0;
        while (pending_sites.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [PAT_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_PATTERN_COUNT:  shadow_cfg.count      = data[CNT_BITS-1:0];
            REG_PATTERN_LENGTH: shadow_cfg.length     = data[LEN_BITS-1:0];
            REG_SITE_OFFSET:    shadow_cfg.offset     = data[OFF_BITS-1:0];
            REG_PATTERN_ZERO:   shadow_cfg.pattern[0] = data;
            REG_PATTERN_ONE:    shadow_cfg.pattern[1] = data;
            REG_PATTERN_TWO:    shadow_cfg.pattern[2] = data;
            REG_PATTERN_THREE:  shadow_cfg.pattern[3] = data;
            default: ;
        endcase
    endtask

    task automatic configure(input cfg_t cfg);
        write_reg(REG_PATTERN_COUNT,  PAT_BITS'(cfg.count));
        write_reg(REG_PATTERN_LENGTH, PAT_BITS'(cfg.length));
        write_reg(REG_SITE_OFFSET,    PAT_BITS'(cfg.offset));
        write_reg(REG_PATTERN_ZERO,   cfg.pattern[0]);
        write_reg(REG_PATTERN_ONE,    cfg.pattern[1]);
        write_reg(REG_PATTERN_TWO,    cfg.pattern[2]);
        write_reg(REG_PATTERN_THREE,  cfg.pattern[3]);
        cfg_valid <= 1'b0;
    endtask

    // defaults, no segment begun: base zero, "ag" at offset 2
    task automatic test_reset_defaults();
        send_word("a", 1'b0, POSITION_BITS'($urandom));
        send_word("g", 1'b0, POSITION_BITS'($urandom));
        send_word("c", 1'b0, POSITION_BITS'($urandom));
        send_word("a", 1'b0, POSITION_BITS'($urandom));
        send_word("g", 1'b0, POSITION_BITS'($urandom));
        drain();
    endtask

    // count and length saturate, largest base and offset, bytes 00/FF
    task automatic test_saturation_extremes();
        cfg_t cfg;
        int   k;
        cfg.count      = 3'd7;
        cfg.length     = 4'd15;
        cfg.offset     = 6'sd31;
        cfg.pattern[0] = '0;
        cfg.pattern[1] = '0;
        cfg.pattern[2] = '0;
        cfg.pattern[3] = 64'hFF00_FF00_FF00_FF00;
        configure(cfg);
        for (k = 0; k < MAX_PATTERN_LEN; k++)
            send_word(k[0] ? 8'hFF : 8'h00, k == 0, '1);
        drain();
    endtask

    // length zero acts as one, most negative offset with base zero
    task automatic test_negative_offset();
        cfg_t cfg;
        cfg.count      = 3'd1;
        cfg.length     = 4'd0;
        cfg.offset     = -6'sd32;
        cfg.pattern[0] = 64'hFFFF_FFFF_FFFF_FF00;
        cfg.pattern[1] = '1;
        cfg.pattern[2] = '1;
        cfg.pattern[3] = '1;
        configure(cfg);
        send_word(8'h00, 1'b1, '0);
        send_word(8'hFF, 1'b0, '1);
        send_word(8'h00, 1'b0, '1);
        drain();
    endtask

    task automatic test_no_patterns();
        cfg_t cfg;
        cfg.count      = 3'd0;
        cfg.length     = 4'd2;
        cfg.offset     = 6'sd0;
        cfg.pattern[0] = 64'h6761;
        cfg.pattern[1] = 64'h6761;
        cfg.pattern[2] = '0;
        cfg.pattern[3] = '0;
        configure(cfg);
        send_word("a", 1'b1, 31'd5);
        send_word("g", 1'b0, 31'd5);
        drain();
    endtask

    // short segment yields nothing, restart clears window, duplicate patterns
    task automatic test_segment_restart();
        cfg_t cfg;
        cfg.count      = 3'd2;
        cfg.length     = 4'd3;
        cfg.offset     = 6'sd0;
        cfg.pattern[0] = 64'h74_6761;
        cfg.pattern[1] = 64'h74_6761;
        cfg.pattern[2] = 64'h6367;
        cfg.pattern[3] = 64'h7467;
        configure(cfg);
        send_word("a", 1'b1, 31'd1000);
        send_word("g", 1'b0, 31'd0);
        send_word("t", 1'b1, 31'd2000);
        send_word("a", 1'b0, 31'd0);
        send_word("g", 1'b0, 31'd0);
        send_word("t", 1'b0, 31'd0);
        drain();
    endtask

    task automatic configure_random();
        cfg_t cfg;
        int   p;
        int   j;
        cfg.count  = ($urandom_range(0, 3) == 0) ? CNT_BITS'($urandom_range(0, 7))
                                                 : CNT_BITS'($urandom_range(1, 4));
        cfg.length = ($urandom_range(0, 3) == 0) ? LEN_BITS'($urandom_range(0, 15))
                                                 : LEN_BITS'($urandom_range(1, 4));
        cfg.offset = OFF_BITS'($urandom_range(0, 63));
        for (p = 0; p < MAX_PATTERNS; p++)
        begin
            if ($urandom_range(0, 3) == 0)
                cfg.pattern[p] = {$urandom, $urandom};
            else
                for (j = 0; j < 8; j++)
                    cfg.pattern[p][8*j +: 8] = random_nucleotide();
        end
        configure(cfg);
    endtask

    // mostly pattern copies and nucleotides, some raw bytes
    task automatic send_segment(input int nchars, input bit fresh);
        sym_t                     text [$];
        logic [POSITION_BITS-1:0] seg_base;
        int unsigned              len;
        int                       roll;
        int                       p;
        int                       j;
        len      = active_length();
        seg_base = random_base();
        while (text.size() < nchars)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
            begin
                p = $urandom_range(0, MAX_PATTERNS - 1);
                for (j = 0; j < len; j++)
                    text = {text, sym_t'(shadow_cfg.pattern[p][8*j +: 8])};
            end
            else if (roll < 45)
                text = {text, sym_t'($urandom_range(0, 255))};
            else
                text = {text, random_nucleotide()};
        end
        foreach (text[k])
            send_word(text[k], fresh && (k == 0),
                      (fresh && (k == 0)) ? seg_base : POSITION_BITS'($urandom));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int rounds);
        int budget;
        int nchars;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (rounds)
        begin
            configure_random();
            budget = $urandom_range(28, 40);
            while (budget > 0)
            begin
                nchars = $urandom_range(1, 16);
                send_segment(nchars, $urandom_range(0, 7) != 0);
                budget -= nchars;
            end
            drain();
        end
    endtask

    initial
    begin
        shadow_cfg.count      = 3'd1;
        shadow_cfg.length     = 4'd2;
        shadow_cfg.offset     = 6'sd2;
        shadow_cfg.pattern    = '0;
        shadow_cfg.pattern[0] = 64'd26465;
        foreach (scan_window[i])
            scan_window[i] = '0;
        scan_index = '0;
        scan_base  = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_saturation_extremes();
        test_negative_offset();
        test_no_patterns();
        test_segment_restart();
        test_random_traffic(0, 0, 3);
        test_random_traffic(47, 0, 3);
        test_random_traffic(0, 47, 3);
        test_random_traffic(15, 15, 3);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
